### src/tpr_pkg.sv
package tpr_pkg;

    localparam int VAL_W  = 24;
    localparam int DIFF_W = VAL_W + 1;
    localparam int NUM_OUT = 6;

    typedef logic signed [VAL_W-1:0]  t_val;
    typedef logic signed [DIFF_W-1:0] t_diff;

    localparam t_val Q_ONE  = 24'sd65536;
    localparam t_val Q_HALF = 24'sd32768;

    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

endpackage

### src/tpr_if.sv
interface tpr_in_if;
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [2:0]             slot;
    tpr_pkg::t_val          target_value;
    logic [15:0]            steps;

    modport source (output valid, opcode, slot, target_value, steps, input ready);
    modport sink   (input valid, opcode, slot, target_value, steps, output ready);
endinterface

interface tpr_out_if;
    logic                   valid;
    logic                   ready;
    tpr_pkg::t_val          param_value_0;
    tpr_pkg::t_val          param_value_1;
    tpr_pkg::t_val          param_value_2;
    tpr_pkg::t_val          param_value_3;
    tpr_pkg::t_val          param_value_4;
    tpr_pkg::t_val          param_value_5;

    modport source (output valid, param_value_0, param_value_1, param_value_2,
                    param_value_3, param_value_4, param_value_5, input ready);
    modport sink   (input valid, param_value_0, param_value_1, param_value_2,
                    param_value_3, param_value_4, param_value_5, output ready);
endinterface

### src/timed_parameter_ramp_unit.sv
// Linear parameter ramp over NUM_SLOTS slots of signed Q8.16 values. A set
// transaction loads one slot's target and step count (a count of zero jumps
// at once), and its result is written to the output register from S_OUT once
// that register is free. A tick transaction walks the slots one by one; each
// slot with steps left moves by (target - value) / remaining through a shared
// one-bit-per-cycle divider. Every transaction returns one result with all six
// values; slots beyond NUM_SLOTS read as zero. A new transaction is taken
// once the previous one has reached the output register.
module timed_parameter_ramp_unit #(
    parameter int NUM_SLOTS  = 6,
    parameter int STEP_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tpr_in_if.sink      i_in,
    tpr_out_if.source   o_out
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int VW    = tpr_pkg::VAL_W;
    localparam int NO    = tpr_pkg::NUM_OUT;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [VW-1:0]          r_cur [NUM_SLOTS];
    logic [VW-1:0]          n_cur [NUM_SLOTS];
    logic [VW-1:0]          r_tgt [NUM_SLOTS];
    logic [VW-1:0]          n_tgt [NUM_SLOTS];
    logic [STEP_WIDTH-1:0]  r_rem [NUM_SLOTS];
    logic [STEP_WIDTH-1:0]  n_rem [NUM_SLOTS];
    logic                   r_out_valid, n_out_valid;
    logic [VW-1:0]          r_out_val [NO];
    logic [VW-1:0]          n_out_val [NO];

    logic [VW-1:0]          w_view [NO];
    logic                   w_acc;
    logic                   w_last;
    logic [STEP_WIDTH-1:0]  w_steps;
    logic                   w_div_start;
    logic                   w_div_done;
    tpr_pkg::t_diff         w_div_q;
    tpr_pkg::t_diff         w_diff;

    for (genvar g = 0; g < NO; g++) begin : g_view
        if (g < NUM_SLOTS) begin : g_live
            assign w_view[g] = r_cur[g];
        end else begin : g_zero
            assign w_view[g] = '0;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_last     = (r_idx == IDX_W'(NUM_SLOTS - 1));
    assign w_steps    = STEP_WIDTH'(i_in.steps);
    assign w_diff     = {r_tgt[r_idx][VW-1], r_tgt[r_idx]} - {r_cur[r_idx][VW-1], r_cur[r_idx]};

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cur       = r_cur;
        n_tgt       = r_tgt;
        n_rem       = r_rem;
        n_out_val   = r_out_val;
        n_out_valid = r_out_valid;
        w_div_start = 1'b0;
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_in.opcode == tpr_pkg::OP_SET) begin
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                            if (32'(i_in.slot) == i) begin
                                n_tgt[i] = i_in.target_value;
                                n_rem[i] = w_steps;
                                if (w_steps == '0) begin
                                    n_cur[i] = i_in.target_value;
                                end
                            end
                        end
                        n_state = S_OUT;
                    end else begin
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_rem[r_idx] != '0) begin
                    w_div_start = 1'b1;
                    n_state     = S_WAIT;
                end else if (w_last) begin
                    n_state = S_OUT;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_WAIT: begin
                if (w_div_done) begin
                    n_cur[r_idx] = r_cur[r_idx] + w_div_q[VW-1:0];
                    n_rem[r_idx] = r_rem[r_idx] - STEP_WIDTH'(1);
                    if (w_last) begin
                        n_state = S_OUT;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_SCAN;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_val   = w_view;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_cur[i] <= (i == 0) ? tpr_pkg::Q_ONE : (i == 3) ? tpr_pkg::Q_HALF : '0;
                r_tgt[i] <= (i == 0) ? tpr_pkg::Q_ONE : (i == 3) ? tpr_pkg::Q_HALF : '0;
                r_rem[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            r_cur       <= n_cur;
            r_tgt       <= n_tgt;
            r_rem       <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_val <= n_out_val;
    end

    tpr_div #(
        .STEP_WIDTH (STEP_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_diff),
        .i_divisor  (r_rem[r_idx]),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.param_value_0 = r_out_val[0];
    assign o_out.param_value_1 = r_out_val[1];
    assign o_out.param_value_2 = r_out_val[2];
    assign o_out.param_value_3 = r_out_val[3];
    assign o_out.param_value_4 = r_out_val[4];
    assign o_out.param_value_5 = r_out_val[5];

    a_wait_has_steps : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WAIT |-> r_rem[r_idx] != '0)
        else $error("Slot under division has no steps left.");

    a_done_in_wait : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_WAIT)
        else $error("Divider finished outside the wait state.");

    a_tick_scans : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_in.opcode == tpr_pkg::OP_TICK |=> r_state == S_SCAN && r_idx == '0)
        else $error("Tick transaction did not start the slot scan.");

endmodule

### src/tpr_div.sv
module tpr_div #(
    parameter int STEP_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  tpr_pkg::t_diff          i_dividend,
    input  logic [STEP_WIDTH-1:0]   i_divisor,
    output logic                    o_done,
    output tpr_pkg::t_diff          o_quotient
);

    localparam int DW    = tpr_pkg::DIFF_W;
    localparam int CNT_W = $clog2(DW);

    logic                   r_busy;
    logic                   r_done;
    logic                   r_neg;
    logic [CNT_W-1:0]       r_cnt;
    logic [DW-1:0]          r_num;
    logic [STEP_WIDTH-1:0]  r_rem;
    logic [STEP_WIDTH-1:0]  r_dvs;

    logic [STEP_WIDTH:0]    w_trial;
    logic                   w_fit;
    logic [STEP_WIDTH:0]    w_diff;

    assign w_trial = {r_rem, r_num[DW-1]};
    assign w_fit   = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DW-1];
            r_num <= i_dividend[DW-1] ? DW'(-i_dividend) : DW'(i_dividend);
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_cnt <= CNT_W'(DW - 1);
        end else if (r_busy) begin
            r_num <= {r_num[DW-2:0], w_fit};
            r_rem <= w_fit ? w_diff[STEP_WIDTH-1:0] : w_trial[STEP_WIDTH-1:0];
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? tpr_pkg::t_diff'(-r_num) : tpr_pkg::t_diff'(r_num);

endmodule

### tb/sv/timed_parameter_ramp_unit_test.sv
class ramp_scoreboard;

    localparam int SLOTS = 6;

    typedef logic [tpr_pkg::NUM_OUT-1:0][tpr_pkg::VAL_W-1:0] t_param_set;

    tpr_pkg::t_val level [SLOTS];
    tpr_pkg::t_val goal  [SLOTS];
    logic [15:0]   left  [SLOTS];
    t_param_set    expected_values [$];
    int unsigned   errors;
    int unsigned   reported;

    function new();
        for (int i = 0; i < SLOTS; i++) begin
            level[i] = '0;
            left[i]  = '0;
        end
        level[0] = tpr_pkg::Q_ONE;
        level[3] = tpr_pkg::Q_HALF;
        for (int i = 0; i < SLOTS; i++) begin
            goal[i] = level[i];
        end
        errors   = 0;
        reported = 0;
    endfunction

    // Applies one accepted transaction to the slot state and queues the values it returns.
    function void note_command(logic op, logic [2:0] slot, tpr_pkg::t_val tgt,
                               logic [15:0] steps);
        int         diff;
        int         step_q;
        t_param_set snap;
        if (op == tpr_pkg::OP_SET) begin
            if (slot < SLOTS) begin
                goal[slot] = tgt;
                if (steps == 0) begin
                    level[slot] = tgt;
                end
                left[slot] = steps;
            end
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                if (left[i] != 0) begin
                    diff     = int'(goal[i]) - int'(level[i]);
                    step_q   = diff / int'(left[i]);
                    level[i] = tpr_pkg::t_val'(int'(level[i]) + step_q);
                    left[i]  = left[i] - 16'd1;
                end
            end
        end
        for (int i = 0; i < tpr_pkg::NUM_OUT; i++) begin
            snap[i] = (i < SLOTS) ? level[i] : '0;
        end
        expected_values = {expected_values, snap};
    endfunction

    function void check_values(t_param_set got);
        t_param_set exp_set;
        if (expected_values.size() == 0) begin
            errors++;
            if (reported < 10) begin
                reported++;
                $display("Unexpected result transaction at %0t", $realtime);
            end
            return;
        end
        exp_set = expected_values.pop_front();
        if (exp_set !== got) begin
            errors++;
            if (reported < 10) begin
                reported++;
                for (int i = 0; i < tpr_pkg::NUM_OUT; i++) begin
                    if (exp_set[i] !== got[i]) begin
                        $display("Mismatch at %0t: param_value_%0d expected %0d, got %0d",
                                 $realtime, i, $signed(exp_set[i]), $signed(got[i]));
                    end
                end
            end
        end
    endfunction

endclass

module timed_parameter_ramp_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_ITEMS = 1350;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int          SETTLE       = 200;

    localparam tpr_pkg::t_val VAL_MAX = 24'sh7FFFFF;
    localparam tpr_pkg::t_val VAL_MIN = 24'sh800000;

    logic           i_clk;
    logic           i_rst_n;
    bit             calm;
    int unsigned    cycles;
    ramp_scoreboard sb;

    tpr_in_if  cmd_if ();
    tpr_out_if res_if ();

    timed_parameter_ramp_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic int unsigned pick_gap();
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    task automatic send_item(logic op, logic [2:0] slot, tpr_pkg::t_val tgt,
                             logic [15:0] steps);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.opcode       <= op;
        cmd_if.slot         <= slot;
        cmd_if.target_value <= tgt;
        cmd_if.steps        <= steps;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        sb.note_command(op, slot, tgt, steps);
    endtask

    task automatic set_slot(logic [2:0] slot, tpr_pkg::t_val tgt, logic [15:0] steps);
        send_item(tpr_pkg::OP_SET, slot, tgt, steps);
    endtask

    task automatic tick(int count);
        repeat (count) send_item(tpr_pkg::OP_TICK, 3'($urandom_range(0, 7)),
                                 tpr_pkg::t_val'($urandom()), 16'($urandom()));
    endtask

    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        while (sb.expected_values.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_item();
        logic          op;
        logic [2:0]    slot;
        tpr_pkg::t_val tgt;
        logic [15:0]   steps;
        int unsigned   r;
        op   = ($urandom_range(0, 99) < 55) ? tpr_pkg::OP_TICK : tpr_pkg::OP_SET;
        slot = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5));
        case ($urandom_range(0, 19))
            0:       tgt = VAL_MAX;
            1:       tgt = VAL_MIN;
            2:       tgt = '0;
            default: tgt = tpr_pkg::t_val'($urandom());
        endcase
        r = $urandom_range(0, 99);
        if (r < 20) begin
            steps = '0;
        end else if (r < 70) begin
            steps = 16'($urandom_range(1, 8));
        end else if (r < 85) begin
            steps = 16'($urandom_range(9, 64));
        end else if (r < 95) begin
            steps = 16'($urandom());
        end else begin
            steps = 16'hFFFF;
        end
        send_item(op, slot, tgt, steps);
    endtask

    initial begin
        logic [tpr_pkg::NUM_OUT-1:0][tpr_pkg::VAL_W-1:0] got;
        int unsigned stall;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
            got[0] = res_if.param_value_0;
            got[1] = res_if.param_value_1;
            got[2] = res_if.param_value_2;
            got[3] = res_if.param_value_3;
            got[4] = res_if.param_value_4;
            got[5] = res_if.param_value_5;
            sb.check_values(got);
        end
    end

    initial begin
        sb = new();
        calm = 1'b0;
        i_rst_n             <= 1'b0;
        cmd_if.valid        <= 1'b0;
        cmd_if.opcode       <= tpr_pkg::OP_SET;
        cmd_if.slot         <= '0;
        cmd_if.target_value <= '0;
        cmd_if.steps        <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A tick on idle slots must return the reset values unchanged.
        tick(1);
        set_slot(3'd0, VAL_MAX, 16'd0);
        set_slot(3'd1, VAL_MIN, 16'd0);
        set_slot(3'd2, VAL_MAX, 16'd1);
        set_slot(3'd3, VAL_MIN, 16'd3);
        set_slot(3'd4, VAL_MAX, 16'hFFFF);
        set_slot(3'd5, -24'sd1, 16'd2);
        set_slot(3'd6, VAL_MAX, 16'd0);
        set_slot(3'd7, VAL_MIN, 16'hFFFF);
        tick(5);
        set_slot(3'd0, VAL_MIN, 16'd2);
        tick(2);
        set_slot(3'd1, VAL_MAX, 16'd7);
        tick(3);
        set_slot(3'd4, '0, 16'd0);
        tick(1);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            random_item();
            if (n == RANDOM_ITEMS / 2) begin
                drain_results();
            end
        end

        cmd_if.valid <= 1'b0;
        while (sb.expected_values.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### filelist.f
src/tpr_pkg.sv
src/tpr_if.sv
src/tpr_div.sv
src/timed_parameter_ramp_unit.sv
tb/sv/timed_parameter_ramp_unit_test.sv
